FILE: hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Group type passed from the front end to the output side, hex lookup.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] PCT_CHAR        = 8'h25;
	localparam int         UPD_QUEUE_DEPTH = 4;
	localparam int         GRP_MAX         = 3;

	// Result bytes caused by one input beat, in emit order.
	typedef struct packed {
		logic [1:0]                 cnt;
		logic [GRP_MAX-1:0][7:0]    bytes;
	} grp_t;

	// Bit 4 set means "not a hex digit".
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
		else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
		return v;
	endfunction

endpackage

FILE: hw/rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// One source byte per input beat; decoded bytes out, one per output beat.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_byte carries the string, a zero byte
// ends it. "%XY" with two hex digits becomes one byte; a broken escape is
// passed through as written. Output channel out_valid/out_stall carries
// out_byte and last_of_run, set on the final result beat of an input beat.
// An input beat gives 0 to 3 result beats.
// The first result of a beat passes the group queue, the group register and the output register.
// Throughput: one input beat per cycle while the group queue has room, one
// result beat per cycle while out_stall is low; beats with several results
// drain at one byte per cycle, so sustained input rate follows the result
// count. When the receiver stalls, the output register holds and the queue
// (QUEUE_DEPTH groups) fills; in_stall rises once it is full.
// Reset clears the escape state, the queue and the output valid flag; no
// beats are offered until new input arrives.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; #(
	parameter int QUEUE_DEPTH = UPD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic q_full, q_push, q_pop, q_nempty;
	grp_t push_grp, q_head;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.push     (q_push),
		.push_grp (push_grp)
	);

	upd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_grp (push_grp),
		.full     (q_full),
		.pop      (q_pop),
		.nempty   (q_nempty),
		.head     (q_head)
	);

	upd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nempty    (q_nempty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

FILE: hw/rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front: escape tracking and classification
// Accepts source bytes, tracks the escape state and builds result groups.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output grp_t       push_grp
);

	typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_t;

	phase_t     phase_q, phase_nxt;
	logic [7:0] held_q, held_nxt;
	logic       accept;
	logic [4:0] hv;
	logic       is_hex;
	grp_t       grp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign hv       = hex_value(in_byte);
	assign is_hex   = (in_byte != 8'h00) && !hv[4];

	always_comb begin
		logic [4:0] hi;
		logic [1:0] n;
		hi        = hex_value(held_q);
		grp.bytes = '0;
		n         = 2'd0;
		held_nxt  = held_q;
		phase_nxt = PH_IDLE;
		if (phase_q == PH_PCT && is_hex) begin
			held_nxt  = in_byte;
			phase_nxt = PH_DIGIT;
		end else if (phase_q == PH_DIGIT && is_hex) begin
			grp.bytes[0] = {hi[3:0], hv[3:0]};
			n            = 2'd1;
		end else begin
			// idle input or broken escape: flush any pending bytes, then treat the byte as idle input
			if (phase_q == PH_PCT || phase_q == PH_DIGIT) begin
				grp.bytes[0] = PCT_CHAR;
				n            = 2'd1;
			end
			if (phase_q == PH_DIGIT) begin
				grp.bytes[1] = held_q;
				n            = 2'd2;
			end
			if (in_byte == PCT_CHAR) begin
				phase_nxt = PH_PCT;
			end else begin
				grp.bytes[n] = in_byte;
				n            = n + 2'd1;
			end
		end
		grp.cnt = n;
	end

	assign push     = accept && (grp.cnt != 2'd0);
	assign push_grp = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

endmodule

FILE: hw/rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue: group queue
// Short FIFO of result groups between front end and output side.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; #(
	parameter int DEPTH = UPD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_grp,
	output logic full,
	input  logic pop,
	output logic nempty,
	output grp_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	grp_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rd_q];
	assign do_pop = pop && nempty;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back: result serializer
// Unpacks queued groups into single result beats through an output register.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nempty,
	input  grp_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	grp_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       out_free;
	logic       emit;
	logic       cur_last;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = out_free && cur_valid_q;
	assign cur_last = (idx_q == cur_q.cnt - 2'd1);
	// refill in the same cycle the last byte of a group leaves
	assign q_pop    = q_nempty && (!cur_valid_q || (emit && cur_last));

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_head;
		if (emit) begin
			out_byte_q <= cur_q.bytes[idx_q];
			last_q     <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (emit) begin
				if (cur_last) cur_valid_q <= 1'b0;
				idx_q <= idx_q + 2'd1;
			end
			if (out_free) out_valid_q <= emit;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule

FILE: sim/url_percent_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_tb: self-checking bench for the URL percent decoder
// Feeds directed and random byte strings under random input gaps and output
// stalls. Each accepted byte is decoded by a behavioral model; result beats
// are checked in order against the bytes the model produced.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
	import upd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_CYCLES   = 8;

	typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} esc_phase_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} dec_char_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	dec_char_t  exp_chars[$];
	esc_phase_e esc_phase = PH_IDLE;
	logic [7:0] held_char = 8'h00;
	int         mismatches = 0;
	int         idle_cycles = 0;
	bit         tx_idle_en = 1'b1;
	bit         rx_idle_en = 1'b1;
	bit         hold_req = 1'b0;
	int         hold_cnt = 0;

	url_percent_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	always #2 clk = ~clk;

	// 0..15 for a hex digit, 16 otherwise
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		return 5'd16;
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'("0" + v);
		if ($urandom_range(1)) return 8'("a" + v - 10);
		return 8'("A" + v - 10);
	endfunction

	// Advance the escape state by one source byte and queue the bytes it emits.
	task automatic decode_char(input logic [7:0] b);
		logic [7:0] emit [3];
		int         n;
		bit         as_idle;
		logic [4:0] nib;
		logic [4:0] hnib;
		dec_char_t  d;
		n = 0;
		as_idle = 1'b0;
		nib = nibble_of(b);
		hnib = nibble_of(held_char);
		case (esc_phase)
			PH_PCT: begin
				if (b != 8'h00 && !nib[4]) begin
					held_char = b;
					esc_phase = PH_DIGIT;
				end else begin
					emit[n++] = PCT_CHAR;
					esc_phase = PH_IDLE;
					as_idle = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (b != 8'h00 && !nib[4]) begin
					emit[n++] = {hnib[3:0], nib[3:0]};
				end else begin
					emit[n++] = PCT_CHAR;
					emit[n++] = held_char;
					as_idle = 1'b1;
				end
				esc_phase = PH_IDLE;
			end
			default: as_idle = 1'b1;
		endcase
		if (as_idle) begin
			if (b == PCT_CHAR) esc_phase = PH_PCT;
			else begin
				esc_phase = PH_IDLE;
				emit[n++] = b;
			end
		end
		for (int i = 0; i < n; i++) begin
			d.ch = emit[i];
			d.last = (i == n - 1);
			exp_chars.push_back(d);
		end
	endtask

	// One input beat: optional gap, then hold valid until accepted.
	task automatic send_char(input logic [7:0] b);
		int gap;
		if (tx_idle_en && $urandom_range(99) < 10) begin
			gap = $urandom_range(3, 1);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		decode_char(b);
	endtask

	task automatic end_send();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Mostly well-formed escapes and plain text, some broken escapes and noise.
	task automatic send_random_text(input int count);
		int sent;
		int r;
		logic [7:0] c;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 45) begin
				c = 8'($urandom_range(255, 1));
				if (c == PCT_CHAR) c = 8'h2f;
				send_char(c);
				sent += 1;
			end else if (r < 75) begin
				send_char(PCT_CHAR);
				send_char(rand_hex_char());
				send_char(rand_hex_char());
				sent += 3;
			end else if (r < 82) begin
				send_char(PCT_CHAR);
				send_char(8'($urandom_range(255)));
				sent += 2;
			end else if (r < 88) begin
				send_char(PCT_CHAR);
				send_char(rand_hex_char());
				send_char(8'($urandom_range(255)));
				sent += 3;
			end else if (r < 94) begin
				send_char(8'h00);
				sent += 1;
			end else begin
				send_char(8'($urandom_range(255)));
				sent += 1;
			end
		end
	endtask

	task automatic test_directed();
		logic [7:0] seq [] = '{
			"%", "4", "1",
			"%", "f", "F",
			"%", "0", "0",            // decoded zero, not a terminator
			"%", "g",                 // broken right after percent
			"%", "4", "%", "B", "@",  // broken after one digit, twice
			"%", "%", "9", "a",       // second percent starts a new escape
			"%", "4", 8'h00,          // terminator flushes percent and digit
			"%", 8'h00,
			8'hff, 8'h80, 8'h00
		};
		foreach (seq[i]) send_char(seq[i]);
		end_send();
	endtask

	task automatic test_random();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_random_text(300);
		end_send();
	endtask

	task automatic test_no_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_random_text(100);
		end_send();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Receiver holds off while the sender keeps offering beats.
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		hold_req = 1'b1;
		send_random_text(50);
		end_send();
		tx_idle_en = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt--;
		end else if (rx_idle_en && $urandom_range(99) < 18) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		dec_char_t d;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_chars.size() == 0) begin
				$display("%0t: unexpected beat out_byte=%h last_of_run=%b",
					$time, out_byte, last_of_run);
				mismatches++;
			end else begin
				d = exp_chars.pop_front();
				if (out_byte !== d.ch) begin
					$display("%0t: out_byte expected %h actual %h", $time, d.ch, out_byte);
					mismatches++;
				end
				if (last_of_run !== d.last) begin
					$display("%0t: last_of_run expected %b actual %b",
						$time, d.last, last_of_run);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("url_percent_decoder_tb: FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random();
		test_no_idle();
		test_backpressure();

		while (exp_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && exp_chars.size() == 0)
			$display("url_percent_decoder_tb: PASS");
		else
			$display("url_percent_decoder_tb: FAIL");
		$finish;
	end

endmodule
